// File: hdl/blm_pkg.sv
// Shared types and constants for the battery level monitor.
// Used by the channel interfaces, the serial divider and the top level.
`timescale 1ns / 1ps
`default_nettype none

package blm_pkg;

  localparam int unsigned WINDOW_DEFAULT = 16;

  // Field widths.
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned VOLT_W   = 13;
  localparam int unsigned LEVEL_W  = 17;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned LOWCNT_W = 6;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_MV    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_MV     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_MV     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTERNAL_MV = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEVEL   = 3'd4;

  localparam logic [VOLT_W-1:0]  EMPTY_MV_RST    = 13'd3300;
  localparam logic [VOLT_W-1:0]  HALF_MV_RST     = 13'd3700;
  localparam logic [VOLT_W-1:0]  FULL_MV_RST     = 13'd4100;
  localparam logic [VOLT_W-1:0]  EXTERNAL_MV_RST = 13'd4500;
  localparam logic [LEVEL_W-1:0] LOW_LEVEL_RST   = 17'd6554;

  // Level map: each half of the ramp spans 2^FRAC_W steps of Q16.
  localparam int unsigned FRAC_W = 15;
  localparam int unsigned LEVEL_FRAC = 16;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 17'd65536;
  localparam logic [LEVEL_W-1:0] LEVEL_HALF = 17'd32768;
  localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 17'd0;

  // Percent product: level * 100 fits in 24 bits.
  localparam int unsigned PROD_W = 24;

  localparam logic [LOWCNT_W-1:0] LOWCNT_MAX      = 6'd63;
  localparam logic [LOWCNT_W-1:0] LOW_BATT_LIMIT  = 6'd30;
  localparam logic [LOWCNT_W-1:0] SHUTDOWN_LIMIT  = 6'd60;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// File: hdl/blm_in_if.sv
// Sample channel of the battery level monitor: valid, ready and one reading.
// Depends on blm_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface blm_in_if;
  import blm_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_mv;

  modport source (output valid, output sample_mv, input ready);
  modport sink   (input valid, input sample_mv, output ready);
endinterface

`default_nettype wire

// File: hdl/blm_out_if.sv
// Result channel of the battery level monitor: valid, ready and the gauge fields.
// Depends on blm_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface blm_out_if;
  import blm_pkg::*;

  logic               valid;
  logic               ready;
  logic [VOLT_W-1:0]  voltage_mv;
  logic [LEVEL_W-1:0] level_q16;
  logic [PCT_W-1:0]   percent;
  logic               batt_low;
  logic               shutdown_request;
  logic               external_power;

  modport source (output valid, output voltage_mv, output level_q16, output percent,
                  output batt_low, output shutdown_request, output external_power,
                  input ready);
  modport sink   (input valid, input voltage_mv, input level_q16, input percent,
                  input batt_low, input shutdown_request, input external_power,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/blm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module blm_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/blm_serial_div.sv
// Restoring divider, one quotient bit per cycle, for the average and level map.
// Depends on blm_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none

module blm_serial_div #(
  parameter int unsigned NUM_W = 28,
  parameter int unsigned DEN_W = 13,
  localparam int unsigned ITER_W = $clog2(NUM_W + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  output blm_pkg::div_status_t   status_o,
  output logic      [NUM_W-1:0]  quot_o
);
  import blm_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [DEN_W:0]    trial;
  logic              fits;

  // The numerator shifts out of the top of quo_q while quotient bits enter below.
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = ITER_W'(NUM_W);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      quo_d  = {quo_q[NUM_W-2:0], fits};
      rem_d  = fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      iter_d = iter_q - 1'b1;
      if (iter_q == ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quo_q;

endmodule

`default_nettype wire

// File: hdl/battery_level_monitor.sv
// Battery level monitor top level: sample ring, running sum, sequencer and flags.
// Depends on blm_pkg, blm_in_if, blm_out_if, blm_ram and blm_serial_div.
//
// Usage: one millivolt reading enters per transaction on in_i. The block doubles
// it, stores it in a ring of WINDOW entries and delivers one result transaction
// on out_o carrying the average voltage, the Q16 level, the percent and the
// low-battery, shutdown and external-power flags.
// Throughput: one item at a time; a new sample is accepted only once the last
// result has been handed to the output register. The shared serial divider
// (one quotient bit per cycle) runs once for the average and, when the
// average lies on the ramp, once more for the level map.
// The ring sits in a RAM with registered read; entries not yet written are
// recognised through the fill count, so reset needs no clearing pass and the
// block is ready as soon as reset is released.
// Reset clears the sum, fill count, write slot, low tick counter and restores
// the register defaults. Configuration writes on cfg_we_i take effect at once.
// If the receiver stalls, the result is held in the output register; the next
// sample is still accepted and processed, and waits before its final step until
// the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module battery_level_monitor #(
  parameter int unsigned WINDOW = blm_pkg::WINDOW_DEFAULT
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  blm_in_if.sink                              in_i,
  blm_out_if.source                           out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [blm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [blm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import blm_pkg::*;

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = $clog2(WINDOW * 8191);
  localparam int unsigned MAP_W  = VOLT_W + FRAC_W;
  localparam int unsigned DIV_NUM_W = (SUM_W > MAP_W) ? SUM_W : MAP_W;
  localparam int unsigned DIV_DEN_W = (CNT_W > VOLT_W) ? CNT_W : VOLT_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_AVG  = 3'd2;
  localparam logic [2:0] ST_MAP  = 3'd3;
  localparam logic [2:0] ST_LVL  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  // Configuration registers.
  logic [VOLT_W-1:0]  empty_mv_q, half_mv_q, full_mv_q, external_mv_q;
  logic [LEVEL_W-1:0] low_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_mv_q    <= EMPTY_MV_RST;
      half_mv_q     <= HALF_MV_RST;
      full_mv_q     <= FULL_MV_RST;
      external_mv_q <= EXTERNAL_MV_RST;
      low_level_q   <= LOW_LEVEL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EMPTY_MV:    empty_mv_q    <= cfg_data_i[VOLT_W-1:0];
        CFG_HALF_MV:     half_mv_q     <= cfg_data_i[VOLT_W-1:0];
        CFG_FULL_MV:     full_mv_q     <= cfg_data_i[VOLT_W-1:0];
        CFG_EXTERNAL_MV: external_mv_q <= cfg_data_i[VOLT_W-1:0];
        CFG_LOW_LEVEL:   low_level_q   <= cfg_data_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  logic [2:0]          state_q, state_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [LOWCNT_W-1:0] lowcnt_q, lowcnt_d;
  logic [VOLT_W-1:0]   doubled_q, doubled_d;
  logic [VOLT_W-1:0]   voltage_q, voltage_d;
  logic [LEVEL_W-1:0]  base_q, base_d;
  logic [LEVEL_W-1:0]  level_q, level_d;
  logic                out_valid_q, out_valid_d;
  logic [VOLT_W-1:0]   out_volt_q, out_volt_d;
  logic [LEVEL_W-1:0]  out_level_q, out_level_d;
  logic [PCT_W-1:0]    out_pct_q, out_pct_d;
  logic                out_low_q, out_low_d;
  logic                out_shut_q, out_shut_d;
  logic                out_ext_q, out_ext_d;

  logic                  ring_full;
  logic                  ram_we;
  logic [VOLT_W-1:0]     ram_rdata;
  logic [VOLT_W-1:0]     old_sample;
  logic                  div_start;
  logic [DIV_NUM_W-1:0]  div_num;
  logic [DIV_DEN_W-1:0]  div_den;
  div_status_t           div_st;
  logic [DIV_NUM_W-1:0]  div_quot;
  logic                  out_free;
  logic [PROD_W-1:0]     prod;
  logic [VOLT_W-1:0]     diff;

  assign ring_full  = count_q == CNT_W'(WINDOW);
  // A slot that has never been written counts as zero.
  assign old_sample = ring_full ? ram_rdata : '0;
  assign out_free   = !out_valid_q || out_o.ready;
  assign prod = (PROD_W'(level_q) << 6) + (PROD_W'(level_q) << 5) + (PROD_W'(level_q) << 2);

  blm_ram #(
    .WIDTH (VOLT_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (doubled_q),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  blm_serial_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .status_o (div_st),
    .quot_o   (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    count_d     = count_q;
    sum_d       = sum_q;
    lowcnt_d    = lowcnt_q;
    doubled_d   = doubled_q;
    voltage_d   = voltage_q;
    base_d      = base_q;
    level_d     = level_q;
    out_valid_d = out_valid_q;
    out_volt_d  = out_volt_q;
    out_level_d = out_level_q;
    out_pct_d   = out_pct_q;
    out_low_d   = out_low_q;
    out_shut_d  = out_shut_q;
    out_ext_d   = out_ext_q;
    ram_we      = 1'b0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    diff        = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          doubled_d = {in_i.sample_mv, 1'b0};
          state_d   = ST_READ;
        end
      end
      ST_READ: begin
        ram_we  = 1'b1;
        sum_d   = sum_q - SUM_W'(old_sample) + SUM_W'(doubled_q);
        slot_d  = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
        count_d = ring_full ? count_q : count_q + 1'b1;
        div_start = 1'b1;
        div_num   = DIV_NUM_W'(sum_d);
        div_den   = DIV_DEN_W'(count_d);
        state_d   = ST_AVG;
      end
      ST_AVG: begin
        if (div_st.done) begin
          voltage_d = div_quot[VOLT_W-1:0];
          state_d   = ST_MAP;
        end
      end
      ST_MAP: begin
        if (voltage_q > full_mv_q) begin
          level_d = LEVEL_FULL;
          state_d = ST_OUT;
        end else if (voltage_q > half_mv_q) begin
          diff      = voltage_q - half_mv_q;
          base_d    = LEVEL_HALF;
          div_start = 1'b1;
          div_num   = DIV_NUM_W'(diff) << FRAC_W;
          div_den   = DIV_DEN_W'(full_mv_q - half_mv_q);
          state_d   = ST_LVL;
        end else if (voltage_q > empty_mv_q) begin
          diff      = voltage_q - empty_mv_q;
          base_d    = LEVEL_ZERO;
          div_start = 1'b1;
          div_num   = DIV_NUM_W'(diff) << FRAC_W;
          div_den   = DIV_DEN_W'(half_mv_q - empty_mv_q);
          state_d   = ST_LVL;
        end else begin
          level_d = LEVEL_ZERO;
          state_d = ST_OUT;
        end
      end
      ST_LVL: begin
        if (div_st.done) begin
          // The ramp quotient reaches 2^FRAC_W at the top of a segment, so the sum
          // still fits the level width.
          level_d = base_q + LEVEL_W'(div_quot[FRAC_W:0]);
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          if (level_q < low_level_q) begin
            lowcnt_d = (lowcnt_q == LOWCNT_MAX) ? lowcnt_q : lowcnt_q + 1'b1;
          end else begin
            lowcnt_d = '0;
          end
          out_valid_d = 1'b1;
          out_volt_d  = voltage_q;
          out_level_d = level_q;
          out_pct_d   = prod[LEVEL_FRAC +: PCT_W];
          out_low_d   = lowcnt_d > LOW_BATT_LIMIT;
          out_shut_d  = lowcnt_d > SHUTDOWN_LIMIT;
          out_ext_d   = voltage_q > external_mv_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      lowcnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      lowcnt_q    <= lowcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    doubled_q   <= doubled_d;
    voltage_q   <= voltage_d;
    base_q      <= base_d;
    level_q     <= level_d;
    out_volt_q  <= out_volt_d;
    out_level_q <= out_level_d;
    out_pct_q   <= out_pct_d;
    out_low_q   <= out_low_d;
    out_shut_q  <= out_shut_d;
    out_ext_q   <= out_ext_d;
  end

  assign in_i.ready             = state_q == ST_IDLE;
  assign out_o.valid            = out_valid_q;
  assign out_o.voltage_mv       = out_volt_q;
  assign out_o.level_q16        = out_level_q;
  assign out_o.percent          = out_pct_q;
  assign out_o.batt_low         = out_low_q;
  assign out_o.shutdown_request = out_shut_q;
  assign out_o.external_power   = out_ext_q;

  // An accepted transaction always starts with the ring read-modify-write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == ST_READ)
    else $error("accepted sample did not move to the ring update");

  // The fill count never passes the window length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(WINDOW))
    else $error("fill count exceeds the window");

  // The divider only finishes while the sequencer is waiting for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == ST_AVG || state_q == ST_LVL))
    else $error("divider finished outside a wait state");

  // A new division is only started once the previous one has finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  // A shutdown request always comes with the low-battery flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_shut_q |-> out_low_q)
    else $error("shutdown request without low battery");

endmodule

`default_nettype wire
